// File: hdl/bbc_pkg.sv
package bbc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	// request queue between front and back; depth must be a power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;

	typedef enum logic [1:0] {
		BR_ROUND  = 2'd0,
		BR_CURLY  = 2'd1,
		BR_SQUARE = 2'd2
	} br_code_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} op_kind_t;

	typedef enum logic [2:0] {
		RSN_OK       = 3'd0,
		RSN_EMPTY    = 3'd1,
		RSN_MISMATCH = 3'd2,
		RSN_OPEN     = 3'd3,
		RSN_OVERFLOW = 3'd4
	} reason_t;

	typedef struct packed {
		op_kind_t op;
		br_code_t code;
		logic     last;
	} item_t;

endpackage

// File: hdl/bbc_front.sv
module bbc_front
	import bbc_pkg::*;
(
	input  logic [7:0] char_byte,
	input  logic       last_char,
	output item_t      item
);

	always_comb begin
		item.last = last_char;
		item.op   = OP_NONE;
		item.code = BR_ROUND;
		case (char_byte)
			CH_LPAREN: begin
				item.op   = OP_PUSH;
				item.code = BR_ROUND;
			end
			CH_LCURLY: begin
				item.op   = OP_PUSH;
				item.code = BR_CURLY;
			end
			CH_LSQUARE: begin
				item.op   = OP_PUSH;
				item.code = BR_SQUARE;
			end
			CH_RPAREN: begin
				item.op   = OP_POP;
				item.code = BR_ROUND;
			end
			CH_RCURLY: begin
				item.op   = OP_POP;
				item.code = BR_CURLY;
			end
			CH_RSQUARE: begin
				item.op   = OP_POP;
				item.code = BR_SQUARE;
			end
			default: begin
				item.op   = OP_NONE;
				item.code = BR_ROUND;
			end
		endcase
	end

endmodule

// File: hdl/bbc_queue.sv
module bbc_queue
	import bbc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_take,
	output item_t rd_item
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_take && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wr_item;
	end

endmodule

// File: hdl/bbc_back.sv
module bbc_back
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  item_t      head,
	output logic       take,
	output logic       res_valid,
	input  logic       res_ready,
	output logic       is_balanced,
	output logic [2:0] fail_reason
);

	br_code_t          stack_mem [STACK_DEPTH];
	br_code_t          top_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              failed_q;
	reason_t           reason_q;
	logic              res_valid_q;
	logic              bal_q;
	reason_t           res_reason_q;

	logic              go;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [CNT_W-1:0]  cnt_op;
	logic              failed_op;
	reason_t           reason_op;
	reason_t           final_reason;
	logic [CNT_W-1:0]  cnt_nx;
	logic              failed_nx;
	reason_t           reason_nx;
	logic [CNT_W-1:0]  raddr_full;

	// a last byte needs the result register free or draining
	assign go   = head_valid && (!head.last || !res_valid_q || res_ready);
	assign take = go;

	always_comb begin
		we        = 1'b0;
		waddr     = cnt_q[ADDR_W-1:0];
		cnt_op    = cnt_q;
		failed_op = failed_q;
		reason_op = reason_q;
		if (go && !failed_q) begin
			case (head.op)
				OP_PUSH: begin
					if (cnt_q == CNT_W'(STACK_DEPTH)) begin
						failed_op = 1'b1;
						reason_op = RSN_OVERFLOW;
					end else begin
						we     = 1'b1;
						cnt_op = cnt_q + CNT_W'(1);
					end
				end
				OP_POP: begin
					if (cnt_q == '0) begin
						failed_op = 1'b1;
						reason_op = RSN_EMPTY;
					end else begin
						cnt_op = cnt_q - CNT_W'(1);
						if (top_q != head.code) begin
							failed_op = 1'b1;
							reason_op = RSN_MISMATCH;
						end
					end
				end
				default: begin
					cnt_op = cnt_q;
				end
			endcase
		end

		if (failed_op)
			final_reason = reason_op;
		else if (cnt_op != '0)
			final_reason = RSN_OPEN;
		else
			final_reason = RSN_OK;

		if (go && head.last) begin
			cnt_nx    = '0;
			failed_nx = 1'b0;
			reason_nx = RSN_OK;
		end else begin
			cnt_nx    = cnt_op;
			failed_nx = failed_op;
			reason_nx = reason_op;
		end

		// prefetch the entry that will be on top next cycle
		raddr_full = cnt_nx - CNT_W'(1);
		raddr      = raddr_full[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			failed_q    <= 1'b0;
			reason_q    <= RSN_OK;
			res_valid_q <= 1'b0;
		end else begin
			cnt_q    <= cnt_nx;
			failed_q <= failed_nx;
			reason_q <= reason_nx;
			if (go && head.last)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && head.last) begin
			bal_q        <= (final_reason == RSN_OK);
			res_reason_q <= final_reason;
		end
	end

	// stack memory, registered read with write-through on a push to the same slot
	always_ff @(posedge clk) begin
		if (we)
			stack_mem[waddr] <= head.code;
		if (we && (waddr == raddr))
			top_q <= head.code;
		else
			top_q <= stack_mem[raddr];
	end

	assign res_valid   = res_valid_q;
	assign is_balanced = bal_q;
	assign fail_reason = res_reason_q;

endmodule

// File: hdl/bracket_balance_checker_unit.sv
// channel | dir | tdata fields (low bit up)                  | side flags
// s       | in  | char_byte[7:0]                             | tlast = last_char
// m       | out | is_balanced[0], fail_reason[3:1], zero[7:4] | none
//
// One byte per clock while the engine does not stall; the stack engine reads its top from a memory
// with registered read, prefetched from the next count, so pops run back to back.
// The last byte is stored in the queue, then its result is registered in the result register.
// Reset clears queue pointers, stack count and failure latch; stack memory is not cleared.
// m_tready low holds the result; the engine stalls only on a last byte while the
// result register is full; the 4-entry queue then takes up to three more requests
// before s_tready drops.
module bracket_balance_checker_unit
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // char_byte[7:0]
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // is_balanced[0], fail_reason[3:1], zero[7:4]
);

	item_t      front_item;
	item_t      head;
	logic       head_valid;
	logic       take;
	logic       is_balanced;
	logic [2:0] fail_reason;

	bbc_front u_front (
		.char_byte (s_tdata),
		.last_char (s_tlast),
		.item      (front_item)
	);

	bbc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_tvalid),
		.wr_ready (s_tready),
		.wr_item  (front_item),
		.rd_valid (head_valid),
		.rd_take  (take),
		.rd_item  (head)
	);

	bbc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.take        (take),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.is_balanced (is_balanced),
		.fail_reason (fail_reason)
	);

	assign m_tdata = {4'b0000, fail_reason, is_balanced};

endmodule
